/* hw/rtl/thq_pkg.sv */
// Shared types and constants of the timer heap queue.
`timescale 1ns / 1ps
`default_nettype none
package thq_pkg;
	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
	localparam int DL_W        = 63;
	localparam int TAG_W       = 16;

	localparam logic [1:0] KIND_ADDED    = 2'd0;
	localparam logic [1:0] KIND_REJECTED = 2'd1;
	localparam logic [1:0] KIND_EXPIRED  = 2'd2;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

	typedef struct packed {
		logic [DL_W-1:0]  deadline;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_SU,
		ST_SU_W,
		ST_CHK,
		ST_CHK_W,
		ST_LAST_W,
		ST_SD_RL,
		ST_SD_RR,
		ST_SD_CMP
	} state_t;
endpackage
`default_nettype wire

/* hw/rtl/thq_mem.sv */
// Heap entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module thq_mem (
	input  wire                           clk,
	input  wire                           we,
	input  wire  [thq_pkg::IDX_W-1:0]     waddr,
	input  thq_pkg::entry_t               wdata,
	input  wire                           re,
	input  wire  [thq_pkg::IDX_W-1:0]     raddr,
	output thq_pkg::entry_t               rdata
);
	thq_pkg::entry_t mem [thq_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/timer_heap_queue.sv */
// Top level of the timer heap queue: sequencer around the heap entry store.
`timescale 1ns / 1ps
`default_nettype none
// Timer queue held as a binary min-heap of 63-bit deadlines with 16-bit tags.
// A word is accepted on a rising edge with start high and busy low. An add
// word (operation 0) stores now + delay (saturating) and sifts it up; a tick
// word (operation 1) advances the millisecond clock and removes every due
// root, one expiry word each. Results appear for one cycle under
// result_valid; last marks the final word caused by an input. The receiver
// cannot stall, so results are simply presented and taken.
// All heap traffic goes through one synchronous memory with one read and one
// write port, so each heap level costs a read-compare-write sequence.
// An add climbs one heap level per read-compare-write sequence; an add to a
// full heap is rejected without touching the heap. A tick reads the root for
// each check unless the heap is empty; each removal that leaves entries behind
// moves the last entry to the root and sifts it down level by level. A tick
// with nothing due yields no word. Busy falls in the cycle that presents the
// last word, and the next word can be accepted at the end of that cycle.
// Reset clears the clock and the heap count; the entry store needs no
// clearing since only entries below the count are ever read.
module timer_heap_queue (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         operation,
	input  wire  [31:0] delay,
	input  wire  [15:0] tag,
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [15:0] expired_tag,
	output logic [62:0] deadline,
	output logic [6:0]  pending,
	output logic        last
);
	localparam int IW = thq_pkg::IDX_W;
	localparam int CW = thq_pkg::CNT_W;
	localparam int XW = thq_pkg::IDX_W + 2;

	thq_pkg::state_t state_q, state_d;
	logic [thq_pkg::DL_W-1:0]   now_q;
	logic [CW-1:0]              count_q;
	logic [IW-1:0]              hole_q;
	logic [thq_pkg::NRES_W-1:0] nres_q;
	thq_pkg::entry_t            x_q, left_q, held_q;
	logic [CW-1:0]              held_pend_q;
	logic                       held_v_q;

	logic            we, re;
	logic [IW-1:0]   waddr, raddr;
	thq_pkg::entry_t wdata, rdata;

	logic            emit_c, emit_last_c;
	logic [1:0]      emit_kind_c;
	thq_pkg::entry_t emit_entry_c;
	logic [CW-1:0]   emit_pend_c;

	logic [XW-1:0]   child_x, count_x, parent_x;
	logic            has_r, sel_l, sel_r, due;
	thq_pkg::entry_t min_lx;
	logic [63:0]     sum;

	thq_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy     = (state_q != thq_pkg::ST_IDLE);
	assign sum      = {1'b0, now_q} + {32'd0, delay};
	assign child_x  = {1'b0, hole_q, 1'b1};
	assign count_x  = XW'(count_q);
	assign parent_x = (XW'(hole_q) - XW'(1)) >> 1;
	assign has_r    = (child_x + XW'(1)) < count_x;
	assign sel_l    = left_q.deadline < x_q.deadline;
	assign min_lx   = sel_l ? left_q : x_q;
	assign sel_r    = has_r && (rdata.deadline < min_lx.deadline);
	assign due      = rdata.deadline <= now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		we           = 1'b0;
		waddr        = hole_q;
		wdata        = x_q;
		re           = 1'b0;
		raddr        = '0;
		emit_c       = 1'b0;
		emit_kind_c  = thq_pkg::KIND_ADDED;
		emit_entry_c = x_q;
		emit_pend_c  = count_q;
		emit_last_c  = 1'b1;
		unique case (state_q)
			thq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (operation == thq_pkg::OP_ADD) ? thq_pkg::ST_ADD
					                                         : thq_pkg::ST_CHK;
				end
			end
			thq_pkg::ST_ADD: begin
				if (count_x >= XW'(thq_pkg::CAPACITY)) begin
					emit_c      = 1'b1;
					emit_kind_c = thq_pkg::KIND_REJECTED;
					state_d     = thq_pkg::ST_IDLE;
				end else begin
					state_d = thq_pkg::ST_SU;
				end
			end
			thq_pkg::ST_SU: begin
				if (hole_q == '0) begin
					we      = 1'b1;
					emit_c  = 1'b1;
					state_d = thq_pkg::ST_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = parent_x[IW-1:0];
					state_d = thq_pkg::ST_SU_W;
				end
			end
			thq_pkg::ST_SU_W: begin
				we = 1'b1;
				if (rdata.deadline <= x_q.deadline) begin
					emit_c  = 1'b1;
					state_d = thq_pkg::ST_IDLE;
				end else begin
					wdata   = rdata;
					state_d = thq_pkg::ST_SU;
				end
			end
			thq_pkg::ST_CHK: begin
				if (count_q != '0 && nres_q < thq_pkg::NRES_W'(thq_pkg::MAX_RESULTS)) begin
					re      = 1'b1;
					state_d = thq_pkg::ST_CHK_W;
				end else begin
					emit_c  = held_v_q;
					state_d = thq_pkg::ST_IDLE;
				end
				emit_kind_c  = thq_pkg::KIND_EXPIRED;
				emit_entry_c = held_q;
				emit_pend_c  = held_pend_q;
			end
			thq_pkg::ST_CHK_W: begin
				emit_c       = held_v_q;
				emit_kind_c  = thq_pkg::KIND_EXPIRED;
				emit_entry_c = held_q;
				emit_pend_c  = held_pend_q;
				emit_last_c  = !due;
				if (!due) begin
					state_d = thq_pkg::ST_IDLE;
				end else if (count_q == CW'(1)) begin
					state_d = thq_pkg::ST_CHK;
				end else begin
					re      = 1'b1;
					raddr   = IW'(count_q - CW'(1));
					state_d = thq_pkg::ST_LAST_W;
				end
			end
			thq_pkg::ST_LAST_W: begin
				state_d = thq_pkg::ST_SD_RL;
			end
			thq_pkg::ST_SD_RL: begin
				if (child_x >= count_x) begin
					we      = 1'b1;
					state_d = thq_pkg::ST_CHK;
				end else begin
					re      = 1'b1;
					raddr   = child_x[IW-1:0];
					state_d = thq_pkg::ST_SD_RR;
				end
			end
			thq_pkg::ST_SD_RR: begin
				re      = has_r;
				raddr   = IW'(child_x + XW'(1));
				state_d = thq_pkg::ST_SD_CMP;
			end
			thq_pkg::ST_SD_CMP: begin
				we = 1'b1;
				if (sel_r) begin
					wdata   = rdata;
					state_d = thq_pkg::ST_SD_RL;
				end else if (sel_l) begin
					wdata   = left_q;
					state_d = thq_pkg::ST_SD_RL;
				end else begin
					state_d = thq_pkg::ST_CHK;
				end
			end
			default: begin
				state_d = thq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			count_q      <= '0;
			nres_q       <= '0;
			held_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit_c;
			if (state_q == thq_pkg::ST_IDLE && start) begin
				nres_q   <= '0;
				held_v_q <= 1'b0;
				if (operation == thq_pkg::OP_TICK && now_q != thq_pkg::DL_MAX) begin
					now_q <= now_q + thq_pkg::DL_W'(1);
				end
			end
			if (state_q == thq_pkg::ST_ADD && count_x < XW'(thq_pkg::CAPACITY)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == thq_pkg::ST_CHK_W && due) begin
				count_q  <= count_q - CW'(1);
				nres_q   <= nres_q + thq_pkg::NRES_W'(1);
				held_v_q <= 1'b1;
			end
		end
	end

	// Data registers of the sequencer; no reset needed.
	always_ff @(posedge clk) begin
		if (emit_c) begin
			kind        <= emit_kind_c;
			expired_tag <= emit_entry_c.tag;
			deadline    <= emit_entry_c.deadline;
			pending     <= 7'(emit_pend_c);
			last        <= emit_last_c;
		end
		unique case (state_q)
			thq_pkg::ST_IDLE: begin
				x_q.tag      <= tag;
				x_q.deadline <= sum[63] ? thq_pkg::DL_MAX : sum[62:0];
			end
			thq_pkg::ST_ADD: begin
				hole_q <= IW'(count_q);
			end
			thq_pkg::ST_SU_W: begin
				if (rdata.deadline > x_q.deadline) begin
					hole_q <= parent_x[IW-1:0];
				end
			end
			thq_pkg::ST_CHK_W: begin
				if (due) begin
					held_q      <= rdata;
					held_pend_q <= count_q - CW'(1);
				end
			end
			thq_pkg::ST_LAST_W: begin
				x_q    <= rdata;
				hole_q <= '0;
			end
			thq_pkg::ST_SD_RR: begin
				left_q <= rdata;
			end
			thq_pkg::ST_SD_CMP: begin
				if (sel_r) begin
					hole_q <= IW'(child_x + XW'(1));
				end else if (sel_l) begin
					hole_q <= child_x[IW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(thq_pkg::CAPACITY))
		else $error("heap count above capacity");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == thq_pkg::KIND_REJECTED
		|-> XW'(count_q) == XW'(thq_pkg::CAPACITY))
		else $error("add rejected while heap not full");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && waddr == raddr))
		else $error("read and write of one entry in the same cycle");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");
endmodule
`default_nettype wire
